>>> rtl/r2h_pkg.sv
`default_nettype none

package r2h_pkg;

   localparam int COMP_W     = 8;
   localparam int SUM_W      = COMP_W + 1;
   localparam int QUO_W      = 20;
   localparam int RQ_W       = COMP_W + QUO_W;
   localparam int DIV_STAGES = 5;
   localparam int DIV_STEPS  = QUO_W / DIV_STAGES;
   localparam int HUE_W      = 15;
   localparam int SAT_W      = 16;
   localparam int HQ_W       = 12;

   localparam logic [HUE_W-1:0] HUE_RED_OFF   = 15'd0;
   localparam logic [HUE_W-1:0] HUE_GREEN_OFF = 15'd7680;
   localparam logic [HUE_W-1:0] HUE_BLUE_OFF  = 15'd15360;
   localparam logic [HUE_W:0]   HUE_FULL      = 16'd23040;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   typedef struct packed {
      logic              grey;
      logic              neg;
      sector_type        sector;
      logic [SUM_W-1:0]  sum;
      logic [COMP_W-1:0] hue_den;
      logic [COMP_W-1:0] sat_den;
      logic [RQ_W-1:0]   hue_rq;
      logic [RQ_W-1:0]   sat_rq;
   } div_type;

   typedef struct packed {
      logic [SUM_W-1:0] lightness_sum;
      logic [SAT_W-1:0] saturation;
      logic [HUE_W-1:0] hue;
   } rsp_type;

   // One restoring division step: remainder in the upper bits, dividend
   // shifting out of and quotient shifting into the lower bits.
   function automatic logic [RQ_W-1:0] div_step(input logic [RQ_W-1:0] rq,
                                                input logic [COMP_W-1:0] den);
      logic [COMP_W:0] top;
      logic            qbit;
      top  = rq[RQ_W-1:QUO_W-1];
      qbit = 1'b0;
      if (top >= {1'b0, den}) begin
         top  = top - {1'b0, den};
         qbit = 1'b1;
      end
      return {top[COMP_W-1:0], rq[QUO_W-2:0], qbit};
   endfunction

endpackage

`default_nettype wire

>>> rtl/r2h_front.sv
`default_nettype none

module r2h_front
   import r2h_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [COMP_W-1:0] red,
   input  wire logic [COMP_W-1:0] green,
   input  wire logic [COMP_W-1:0] blue,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output div_type                out_data
);

   logic              vld_ff;
   div_type           data_ff;
   div_type           data_in;
   logic [COMP_W-1:0] mx;
   logic [COMP_W-1:0] mn;
   logic [COMP_W-1:0] op_a;
   logic [COMP_W-1:0] op_b;
   logic [COMP_W:0]   diff;
   logic [COMP_W:0]   neg_diff;
   logic [COMP_W-1:0] absv;
   logic [HQ_W-1:0]   x15;
   logic [SUM_W-1:0]  sum;
   logic [SUM_W-1:0]  inv_sum;
   logic [COMP_W-1:0] d;
   sector_type        sector;

   assign in_ready = !vld_ff || out_ready;

   always_comb begin
      if (red >= green && red >= blue) begin
         sector = SECTOR_RED;
         mx     = red;
         op_a   = green;
         op_b   = blue;
      end else if (green >= blue) begin
         sector = SECTOR_GREEN;
         mx     = green;
         op_a   = blue;
         op_b   = red;
      end else begin
         sector = SECTOR_BLUE;
         mx     = blue;
         op_a   = red;
         op_b   = green;
      end
      mn = (red <= green) ? red : green;
      if (blue < mn) begin
         mn = blue;
      end
      diff     = {1'b0, op_a} - {1'b0, op_b};
      neg_diff = {1'b0, op_b} - {1'b0, op_a};
      absv     = diff[COMP_W] ? neg_diff[COMP_W-1:0] : diff[COMP_W-1:0];
      x15      = {absv, 4'b0000} - {4'b0000, absv};
      sum      = {1'b0, mx} + {1'b0, mn};
      inv_sum  = 9'd510 - sum;
      d        = mx - mn;

      data_in.grey    = (d == '0);
      data_in.neg     = diff[COMP_W];
      data_in.sector  = sector;
      data_in.sum     = sum;
      data_in.hue_den = d;
      data_in.sat_den = (sum < 9'd255) ? sum[COMP_W-1:0] : inv_sum[COMP_W-1:0];
      data_in.hue_rq  = {{COMP_W{1'b0}}, x15, 8'h00};
      data_in.sat_rq  = {4'b0000, d, 16'h0000};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

>>> rtl/r2h_divider.sv
`default_nettype none

module r2h_divider
   import r2h_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire div_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output div_type      out_data
);

   logic    vld_ff  [DIV_STAGES];
   div_type data_ff [DIV_STAGES];
   div_type data_in [DIV_STAGES];
   logic    stage_rdy [DIV_STAGES+1];

   always_comb begin
      stage_rdy[DIV_STAGES] = out_ready;
      for (int i = DIV_STAGES - 1; i >= 0; i--) begin
         stage_rdy[i] = !vld_ff[i] || stage_rdy[i+1];
      end
   end

   always_comb begin
      for (int i = 0; i < DIV_STAGES; i++) begin
         data_in[i] = (i == 0) ? in_data : data_ff[(i == 0) ? 0 : i - 1];
         for (int s = 0; s < DIV_STEPS; s++) begin
            data_in[i].hue_rq = div_step(data_in[i].hue_rq, data_in[i].hue_den);
            data_in[i].sat_rq = div_step(data_in[i].sat_rq, data_in[i].sat_den);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STAGES; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         for (int i = 0; i < DIV_STAGES; i++) begin
            if (stage_rdy[i]) begin
               vld_ff[i] <= (i == 0) ? in_valid : vld_ff[(i == 0) ? 0 : i - 1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
         if (stage_rdy[i]) begin
            data_ff[i] <= data_in[i];
         end
      end
   end

   assign in_ready  = stage_rdy[0];
   assign out_valid = vld_ff[DIV_STAGES-1];
   assign out_data  = data_ff[DIV_STAGES-1];

   // The partial remainder of a pixel with color must stay below its divisor.
   assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_data.grey |->
         out_data.hue_rq[RQ_W-1:QUO_W] < out_data.hue_den)
      else $error("hue remainder not below divisor");

   assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_data.grey |->
         out_data.sat_rq[RQ_W-1:QUO_W] < out_data.sat_den)
      else $error("saturation remainder not below divisor");

   assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_data.grey |-> out_data.sat_rq[QUO_W-1:0] <= 20'h10000)
      else $error("saturation quotient out of range");

endmodule

`default_nettype wire

>>> rtl/r2h_back.sv
`default_nettype none

module r2h_back
   import r2h_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire div_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output rsp_type      out_data
);

   logic             vld_ff;
   rsp_type          data_ff;
   rsp_type          data_in;
   logic [HUE_W-1:0] off;
   logic [HQ_W-1:0]  hq;
   logic [QUO_W-1:0] sq;
   logic [HUE_W:0]   hue_pos;
   logic [HUE_W:0]   hue_neg;
   logic [HUE_W:0]   hue_wrap;
   logic [HUE_W:0]   hue_full;

   assign in_ready = !vld_ff || out_ready;

   always_comb begin
      unique case (in_data.sector)
         SECTOR_RED:   off = HUE_RED_OFF;
         SECTOR_GREEN: off = HUE_GREEN_OFF;
         SECTOR_BLUE:  off = HUE_BLUE_OFF;
         default:      off = HUE_RED_OFF;
      endcase
      hq       = in_data.hue_rq[HQ_W-1:0];
      sq       = in_data.sat_rq[QUO_W-1:0];
      hue_pos  = {1'b0, off} + {4'b0000, hq};
      hue_neg  = {1'b0, off} - {4'b0000, hq};
      hue_wrap = hue_neg + HUE_FULL;
      if (!in_data.neg) begin
         hue_full = hue_pos;
      end else if (hue_neg[HUE_W]) begin
         hue_full = hue_wrap;
      end else begin
         hue_full = hue_neg;
      end

      data_in.lightness_sum = in_data.sum;
      if (in_data.grey) begin
         data_in.hue        = '0;
         data_in.saturation = '0;
      end else begin
         data_in.hue        = hue_full[HUE_W-1:0];
         data_in.saturation = (sq[QUO_W-1:SAT_W] != '0) ? {SAT_W{1'b1}} : sq[SAT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

>>> rtl/rgb_to_hsl_converter.sv
// An accepted input transaction reaches its result through one front stage,
// five divider stages and one output register. Throughput: one pixel per
// cycle while rsp_tready does not stall the pipeline; each divider stage
// retires four quotient bits of both the hue and the saturation divisions.
// Reset clears all stage valid bits; data registers are not reset.
`default_nettype none

module rgb_to_hsl_converter
   import r2h_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // red [7:0], green [15:8], blue [23:16]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata   // hue [14:0], saturation [30:15],
                                        // lightness_sum [39:31]
);

   logic    front_valid;
   logic    front_ready;
   div_type front_data;
   logic    div_valid;
   logic    div_ready;
   div_type div_data;
   rsp_type rsp_data;

   r2h_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .red       (req_tdata[7:0]),
      .green     (req_tdata[15:8]),
      .blue      (req_tdata[23:16]),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   r2h_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   r2h_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_data   (div_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tdata = rsp_data;

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_data.hue < 15'd23040)
      else $error("hue out of range");

   // Black and white pixels are grey and carry neither hue nor saturation.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_data.lightness_sum == 9'd0 || rsp_data.lightness_sum == 9'd510)
      |-> rsp_data.hue == '0 && rsp_data.saturation == '0)
      else $error("black or white pixel with hue or saturation");

endmodule

`default_nettype wire
